// ----- src/lmpw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpw_pkg
// Shared types for the latency metrics and percentile window block.
// ----------------------------------------------------------------------------
package lmpw_pkg;

  // Item kinds on the input channel.
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam int unsigned CntW = 48;
  localparam int unsigned LatW = 32;
  localparam int unsigned NumPct = 3;

  typedef struct packed {
    logic        kind;
    logic [31:0] lat_usec;
    logic        err_flag;
    logic        hit_flag;
    logic [31:0] rx_bytes;
    logic [31:0] tx_bytes;
  } in_t;

  typedef struct packed {
    logic [47:0] cmd_total;
    logic [47:0] err_total;
    logic [47:0] total_hits;
    logic [47:0] total_misses;
    logic [47:0] rx_total;
    logic [47:0] tx_total;
    logic [31:0] latency_max;
    logic [16:0] hit_ratio;
    logic [31:0] median_latency;
    logic [31:0] p99_latency;
    logic [31:0] p999_latency;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic record;
    logic load;
    logic div_step;
    logic scan_rd;
    logic decide;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic addr_last;
    logic bit_last;
    logic n_zero;
    logic out_busy;
  } status_t;

endpackage

// ----- src/lmpw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lmpw_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/lmpw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpw_ctrl
// Controller: takes input beats and sequences a query through rank division,
// the radix selection passes and the result hand-off.
// ----------------------------------------------------------------------------
module lmpw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_stall_o,
  input  lmpw_pkg::status_t status_i,
  output lmpw_pkg::cmd_t    cmd_o
);
  import lmpw_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_QUERY) begin
            cmd_o.load = 1'b1;
            state_d    = ST_DIV;
          end else begin
            cmd_o.record = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = status_i.n_zero ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = status_i.bit_last ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/lmpw_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpw_dp
// Datapath: counters, sample window, rank reciprocals, hit-rate divider,
// radix selection of three percentiles and the output register.
// ----------------------------------------------------------------------------
module lmpw_dp #(
  parameter int unsigned Depth = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_data_i,
  input  lmpw_pkg::in_t     in_data_i,
  input  lmpw_pkg::cmd_t    cmd_i,
  output lmpw_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lmpw_pkg::out_t    out_data_o
);
  import lmpw_pkg::*;

  localparam int unsigned AW      = $clog2(Depth);
  localparam int unsigned CW      = $clog2(Depth + 1);
  localparam int unsigned HrSteps = 17;
  localparam int unsigned SW      = $clog2(HrSteps);
  // Reciprocals for the rank terms: (y * Recip) >> Shift equals y / 100 or
  // y / 1000, rounded down, for every y below 2^RW.
  localparam int unsigned RW        = 18;
  localparam int unsigned Shift100  = 26;
  localparam int unsigned Shift1000 = 28;
  localparam int unsigned P100W     = RW + 20;
  localparam int unsigned P1000W    = RW + 19;
  localparam logic [19:0] Recip100  = 20'd671089;
  localparam logic [18:0] Recip1000 = 19'd268436;

  // Configuration and statistics registers.
  logic            enabled_q;
  logic [CntW-1:0] cmd_cnt_q, err_cnt_q, hit_cnt_q, miss_cnt_q, rx_sum_q, tx_sum_q;
  logic [LatW-1:0] max_q;
  logic [AW-1:0]   slot_q;
  logic [CW-1:0]   nvalid_q;
  logic            rec;

  function automatic logic [CntW-1:0] sat_add(logic [CntW-1:0] a, logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

  assign rec = cmd_i.record && enabled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      cmd_cnt_q  <= '0;
      err_cnt_q  <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      rx_sum_q   <= '0;
      tx_sum_q   <= '0;
      max_q      <= '0;
      slot_q     <= '0;
      nvalid_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        enabled_q <= cfg_data_i;
      end
      if (rec) begin
        cmd_cnt_q <= sat_add(cmd_cnt_q, CntW'(1));
        if (in_data_i.err_flag) begin
          err_cnt_q <= sat_add(err_cnt_q, CntW'(1));
        end
        if (in_data_i.hit_flag) begin
          hit_cnt_q <= sat_add(hit_cnt_q, CntW'(1));
        end else begin
          miss_cnt_q <= sat_add(miss_cnt_q, CntW'(1));
        end
        rx_sum_q <= sat_add(rx_sum_q, CntW'(in_data_i.rx_bytes));
        tx_sum_q <= sat_add(tx_sum_q, CntW'(in_data_i.tx_bytes));
        if (in_data_i.lat_usec > max_q) begin
          max_q <= in_data_i.lat_usec;
        end
        slot_q <= (slot_q == AW'(Depth - 1)) ? '0 : slot_q + AW'(1);
        if (nvalid_q != CW'(Depth)) begin
          nvalid_q <= nvalid_q + CW'(1);
        end
      end
    end
  end

  // Sample window memory.
  logic [AW-1:0]   raddr_q;
  logic [LatW-1:0] rdata;

  lmpw_ram #(.Width(LatW), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (rec),
    .waddr_i(slot_q),
    .wdata_i(in_data_i.lat_usec),
    .raddr_i(raddr_q),
    .rdata_o(rdata)
  );

  // Hit-rate divider, one quotient bit a step, and the rank reciprocals.
  logic [SW-1:0]     step_q;
  logic [CntW:0]     acc_q;
  logic [CntW+1:0]   hrem_q, hrem_d;
  logic [16:0]       hq_q, hq_d;
  logic [CW-1:0]     n_q;
  logic              div_done;
  logic [RW-1:0]     y100, y1000;
  logic [P100W-1:0]  p100;
  logic [P1000W-1:0] p1000;
  logic [CW-1:0]     c100, c1000;

  assign div_done = (step_q == SW'(HrSteps - 1));

  always_comb begin
    hrem_d = hrem_q;
    hq_d   = {hq_q[15:0], 1'b0};
    if (hrem_q >= {1'b0, acc_q}) begin
      hrem_d = hrem_q - {1'b0, acc_q};
      hq_d   = {hq_q[15:0], 1'b1};
    end
    hrem_d = {hrem_d[CntW:0], 1'b0};
  end

  // Ranks of p99 and p99.9 are n minus ceil(n/100) and n minus ceil(n/1000).
  always_comb begin
    y100  = RW'(n_q) + RW'(99);
    y1000 = RW'(n_q) + RW'(999);
    p100  = P100W'(y100) * P100W'(Recip100);
    p1000 = P1000W'(y1000) * P1000W'(Recip1000);
    c100  = CW'(p100 >> Shift100);
    c1000 = CW'(p1000 >> Shift1000);
  end

  // Radix selection state for the three percentiles.
  logic [LatW-1:0] pre_q  [NumPct];
  logic [CW-1:0]   rank_q [NumPct];
  logic [CW-1:0]   cnt_q  [NumPct];
  logic [4:0]      bit_q;
  logic            rd_vld_q;
  logic [32:0]     mask_w;
  logic [LatW-1:0] mask;
  logic            match [NumPct];

  assign mask_w = {33{1'b1}} << ({1'b0, bit_q} + 6'd1);
  assign mask   = mask_w[31:0];

  always_comb begin
    for (int j = 0; j < NumPct; j++) begin
      match[j] = (((rdata ^ pre_q[j]) & mask) == '0) && !rdata[bit_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      bit_q    <= 5'd31;
      raddr_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        step_q  <= '0;
        bit_q   <= 5'd31;
        raddr_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + SW'(1);
      end
      if (cmd_i.scan_rd) begin
        raddr_q <= raddr_q + AW'(1);
      end else if (cmd_i.decide) begin
        raddr_q <= '0;
        bit_q   <= bit_q - 5'd1;
      end
    end
  end

  // Payload registers of a query in progress.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= nvalid_q;
      acc_q  <= {1'b0, hit_cnt_q} + {1'b0, miss_cnt_q};
      hrem_q <= {2'b00, hit_cnt_q};
      hq_q   <= '0;
      for (int j = 0; j < NumPct; j++) begin
        pre_q[j] <= '0;
        cnt_q[j] <= '0;
      end
      rank_q[0] <= nvalid_q >> 1;
    end
    if (cmd_i.div_step) begin
      hrem_q <= hrem_d;
      hq_q   <= hq_d;
      if (div_done) begin
        rank_q[1] <= n_q - c100;
        rank_q[2] <= n_q - c1000;
      end
    end
    // Count samples under each prefix whose current bit is clear.
    if (rd_vld_q) begin
      for (int j = 0; j < NumPct; j++) begin
        if (match[j]) begin
          cnt_q[j] <= cnt_q[j] + CW'(1);
        end
      end
    end
    // Settle one bit of each percentile per pass.
    if (cmd_i.decide) begin
      for (int j = 0; j < NumPct; j++) begin
        cnt_q[j] <= '0;
        if (rank_q[j] >= cnt_q[j]) begin
          pre_q[j][bit_q] <= 1'b1;
          rank_q[j]       <= rank_q[j] - cnt_q[j];
        end
      end
    end
  end

  // Output register.
  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.cmd_total      <= cmd_cnt_q;
      out_q.err_total      <= err_cnt_q;
      out_q.total_hits     <= hit_cnt_q;
      out_q.total_misses   <= miss_cnt_q;
      out_q.rx_total       <= rx_sum_q;
      out_q.tx_total       <= tx_sum_q;
      out_q.latency_max    <= max_q;
      out_q.hit_ratio      <= (acc_q == '0) ? '0 : hq_q;
      out_q.median_latency <= pre_q[0];
      out_q.p99_latency    <= pre_q[1];
      out_q.p999_latency   <= pre_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.div_done  = div_done;
  assign status_o.addr_last = (CW'(raddr_q) == n_q - CW'(1));
  assign status_o.bit_last  = (bit_q == 5'd0);
  assign status_o.n_zero    = (n_q == '0);
  assign status_o.out_busy  = out_valid_q && out_stall_i;

endmodule

// ----- src/latency_metrics_percentile_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_metrics_percentile_window
// Command latency statistics with a sliding window of percentile samples.
// ----------------------------------------------------------------------------
// A record beat is taken while the block is idle, and records follow back to
// back. A query stalls the input after its own beat through hit-rate
// division, then, unless the window is empty, 32 passes over the sample
// memory that find the percentiles bit by bit, each pass reading one sample
// a cycle through the single read port and passing a drain and a decide
// state to settle the bit, with p50, p99 and p99.9 settled together, and
// then until the result is loaded into the output register.
// A finished result waits in the output register while records are taken; a
// later query waits at its end for as long as the previous result is stalled.
module latency_metrics_percentile_window #(
  parameter int unsigned RESERVOIR_DEPTH = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lmpw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lmpw_pkg::out_t out_data_o
);
  import lmpw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The enable register can always be written.
  assign cfg_ready_o = 1'b1;

  lmpw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_kind_i (in_data_i.kind),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lmpw_dp #(.Depth(RESERVOIR_DEPTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- src/lmpw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpw_checker
// Port-level checks of the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module lmpw_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input lmpw_pkg::in_t in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i
);
  import lmpw_pkg::*;

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A query beat puts the block into its busy phase.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.kind == KIND_QUERY |=> in_stall_o)
    else $error("query taken without entering the busy phase");

  // A result appears only at the end of a query.
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared outside a query");

  // A record beat produces no busy phase.
  a_record_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.kind == KIND_RECORD |=> !in_stall_o)
    else $error("record beat stalled the input");

endmodule

bind latency_metrics_percentile_window lmpw_checker u_lmpw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i)
);
